// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the I2C byte write core.
// No dependencies; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hw/rtl/i2cmbw_pkg.sv =====
// Shared types and constants of the I2C byte write core.
// No dependencies; the interfaces, sequencer, result stage and core refer to it by scoped names.
`timescale 1ns / 1ps

package i2cmbw_pkg;

    localparam int unsigned HALF_W = 16;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd5;

    // One result per timebase tick: line drives and status.
    typedef struct packed {
        logic scl_drive_low;
        logic sda_drive_low;
        logic busy_res;
        logic done_res;
        logic addr_acked;
    } t_result;

endpackage

// ===== hw/rtl/i2cmbw_if.sv =====
// Channel interfaces of the I2C byte write core: tick input, result output, config write.
// Depends on i2cmbw_pkg for the configuration width.
`timescale 1ns / 1ps

interface i2cmbw_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [6:0] dev_addr;
    logic [7:0] data_byte;
    logic       sda_in;

    modport source (output valid, cmd, dev_addr, data_byte, sda_in, input ready);
    modport sink   (input valid, cmd, dev_addr, data_byte, sda_in, output ready);
endinterface

interface i2cmbw_out_if;
    logic valid;
    logic ready;
    logic scl_drive_low;
    logic sda_drive_low;
    logic busy_res;
    logic done_res;
    logic addr_acked;

    modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    addr_acked, input ready);
    modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                    addr_acked, output ready);
endinterface

interface i2cmbw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [i2cmbw_pkg::HALF_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/i2cmbw_fsm.sv =====
// Bus sequencer of the I2C byte write core: phase, bit counter, shifter, wait counter.
// Depends on i2cmbw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cmbw_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [i2cmbw_pkg::HALF_W-1:0] i_cfg_data,
    input  logic                          i_step,
    input  logic                          i_cmd,
    input  logic [6:0]                    i_dev_addr,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_sda_in,
    output i2cmbw_pkg::t_result           o_res
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_BIT_LOW  = 4'd2,
        PH_BIT_HIGH = 4'd3,
        PH_ACK_LOW  = 4'd4,
        PH_ACK_HIGH = 4'd5,
        PH_STOP_LOW = 4'd6,
        PH_STOP_SCL = 4'd7,
        PH_STOP_SDA = 4'd8
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [3:0]                      r_bit, n_bit;
    logic [7:0]                      r_shift, n_shift;
    logic [7:0]                      r_pending, n_pending;
    logic [i2cmbw_pkg::HALF_W-1:0]   r_wait, n_wait;
    logic [i2cmbw_pkg::HALF_W-1:0]   r_half;
    logic                            r_ack, n_ack;
    logic                            r_sending, n_sending;
    logic                            r_scl, n_scl;
    logic                            r_sda, n_sda;
    logic                            n_done;

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_pending = r_pending;
        n_wait    = r_wait;
        n_ack     = r_ack;
        n_sending = r_sending;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_done    = 1'b0;
        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                if (i_cmd) begin
                    n_shift   = {i_dev_addr, 1'b0};
                    n_pending = i_data_byte;
                    n_ack     = 1'b0;
                    n_sending = 1'b0;
                    n_bit     = 4'd0;
                    n_phase   = PH_START;
                    n_scl     = 1'b0;
                    n_sda     = 1'b1;
                    n_wait    = r_half;
                end
            end else if (r_wait > 16'd1) begin
                n_wait = r_wait - 16'd1;
            end else begin
                // A step length of zero or one advances on the first tick.
                n_wait = r_half;
                unique case (r_phase)
                    PH_START: begin
                        n_bit   = 4'd0;
                        n_phase = PH_BIT_LOW;
                        n_scl   = 1'b1;
                        n_sda   = ~r_shift[7];
                    end
                    PH_BIT_LOW: begin
                        n_phase = PH_BIT_HIGH;
                        n_scl   = 1'b0;
                    end
                    PH_BIT_HIGH: begin
                        n_bit   = r_bit + 4'd1;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                        if (n_bit < 4'd8) begin
                            n_phase = PH_BIT_LOW;
                            n_sda   = ~n_shift[7];
                        end else begin
                            n_phase = PH_ACK_LOW;
                            n_sda   = 1'b0;
                        end
                    end
                    PH_ACK_LOW: begin
                        n_phase = PH_ACK_HIGH;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                    end
                    PH_ACK_HIGH: begin
                        // Only an acknowledged address leads on to the data byte.
                        if (!r_sending && !i_sda_in) begin
                            n_ack     = 1'b1;
                            n_sending = 1'b1;
                            n_shift   = r_pending;
                            n_bit     = 4'd0;
                            n_phase   = PH_BIT_LOW;
                            n_scl     = 1'b1;
                            n_sda     = ~r_pending[7];
                        end else begin
                            n_phase = PH_STOP_LOW;
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                        end
                    end
                    PH_STOP_LOW: begin
                        n_phase = PH_STOP_SCL;
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                    end
                    PH_STOP_SCL: begin
                        n_phase = PH_STOP_SDA;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                    end
                    PH_STOP_SDA: begin
                        n_done    = 1'b1;
                        n_phase   = PH_IDLE;
                        n_scl     = 1'b0;
                        n_sda     = 1'b0;
                        n_wait    = '0;
                        n_sending = 1'b0;
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_scl     = 1'b0;
                        n_sda     = 1'b0;
                        n_wait    = '0;
                        n_sending = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= 4'd0;
            r_shift   <= 8'd0;
            r_pending <= 8'd0;
            r_wait    <= '0;
            r_half    <= i2cmbw_pkg::HALF_PERIOD_RESET;
            r_ack     <= 1'b0;
            r_sending <= 1'b0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_pending <= n_pending;
            r_wait    <= n_wait;
            r_ack     <= n_ack;
            r_sending <= n_sending;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            if (i_cfg_valid) begin
                r_half <= i_cfg_data;
            end
        end
    end

    // The result shows the state after the tick.
    assign o_res.scl_drive_low = n_scl;
    assign o_res.sda_drive_low = n_sda;
    assign o_res.busy_res      = (n_phase != PH_IDLE);
    assign o_res.done_res      = n_done;
    assign o_res.addr_acked    = n_ack;

    `ASSERT_RST(a_bit_range, i_clk, i_rst_n, r_bit <= 4'd8)
    `ASSERT_RST(a_sending_acked, i_clk, i_rst_n, r_sending |-> r_ack)
    `ASSERT_RST(a_idle_released, i_clk, i_rst_n,
        (r_phase == PH_IDLE) |-> (!r_scl && !r_sda && r_wait == '0))
    `ASSERT_RST(a_request_starts, i_clk, i_rst_n,
        (i_step && i_cmd && r_phase == PH_IDLE) |=> (r_phase == PH_START && !r_ack))

endmodule

// ===== hw/rtl/i2cmbw_out_stage.sv =====
// Result register of the I2C byte write core, with the ready logic that parts the channels.
// Depends on i2cmbw_pkg.
`timescale 1ns / 1ps

module i2cmbw_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cmbw_pkg::t_result i_res,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_valid,
    output i2cmbw_pkg::t_result o_res
);

    logic                r_valid;
    i2cmbw_pkg::t_result r_res;

    // A new tick is taken when the register is empty or the held result leaves in the same cycle.
    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/i2c_master_byte_write_core.sv =====
// I2C master for one single-byte write. Each input transaction is one timebase tick and
// yields exactly one result, which the result register holds; a tick is taken
// in every cycle in which that register is empty or is being read, so the core runs at
// one tick per clock. A request (cmd 1) while idle sends start, address with R/W 0, ack,
// the data byte only if the address was acknowledged, and stop; each line step lasts
// half_period_ticks ticks (0 acts as 1). Configuration writes are always accepted.
// Depends on i2cmbw_pkg, i2cmbw_if, i2cmbw_fsm and i2cmbw_out_stage.
`timescale 1ns / 1ps

module i2c_master_byte_write_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cmbw_in_if.sink     i_in,
    i2cmbw_out_if.source  o_out,
    i2cmbw_cfg_if.sink    i_cfg
);

    logic                in_ready;
    logic                step;
    i2cmbw_pkg::t_result res_next;
    i2cmbw_pkg::t_result res_held;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign step        = i_in.valid && in_ready;

    i2cmbw_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_step      (step),
        .i_cmd       (i_in.cmd),
        .i_dev_addr  (i_in.dev_addr),
        .i_data_byte (i_in.data_byte),
        .i_sda_in    (i_in.sda_in),
        .o_res       (res_next)
    );

    i2cmbw_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res       (res_next),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_out.valid),
        .o_res       (res_held)
    );

    assign o_out.scl_drive_low = res_held.scl_drive_low;
    assign o_out.sda_drive_low = res_held.sda_drive_low;
    assign o_out.busy_res      = res_held.busy_res;
    assign o_out.done_res      = res_held.done_res;
    assign o_out.addr_acked    = res_held.addr_acked;

endmodule

// ===== tb/tb_i2c_master_byte_write_core.sv =====
// Self-checking testbench of the I2C single-byte write core.
// Depends on i2cmbw_pkg, the channel interfaces in i2cmbw_if and i2c_master_byte_write_core.
`timescale 1ns / 1ps

module tb_i2c_master_byte_write_core;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_BIT_SCL_LOW,
        S_BIT_SCL_HIGH,
        S_ACK_SCL_LOW,
        S_ACK_SCL_HIGH,
        S_STOP_SCL_LOW,
        S_STOP_SCL_REL,
        S_STOP_SDA_REL
    } t_bus_step;

    logic i_clk;
    logic i_rst_n;

    i2cmbw_in_if  tick_ch ();
    i2cmbw_out_if bus_ch ();
    i2cmbw_cfg_if cfg_ch ();

    i2c_master_byte_write_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (bus_ch),
        .i_cfg   (cfg_ch)
    );

    // Own model of the bus sequencer, advanced once per accepted tick.
    t_bus_step   m_step;
    bit [3:0]    m_bit_cnt;
    bit [7:0]    m_shift;
    bit [7:0]    m_data_hold;
    bit [15:0]   m_wait;
    bit [15:0]   m_half;
    bit          m_acked;
    bit          m_in_data;
    bit          m_scl_low;
    bit          m_sda_low;

    i2cmbw_pkg::t_result expected_bus[$];
    int          mismatches;
    int          ticks_taken;
    int          cfg_taken;
    int          burst_left;

    function automatic void enter_step(t_bus_step step, bit scl_low, bit sda_low);
        m_step    = step;
        m_scl_low = scl_low;
        m_sda_low = sda_low;
        m_wait    = m_half;
    endfunction

    function automatic i2cmbw_pkg::t_result predict_tick(bit cmd, bit [6:0] addr,
                                                         bit [7:0] data, bit sda);
        i2cmbw_pkg::t_result r;
        bit      done;
        done = 1'b0;
        if (m_step == S_IDLE) begin
            if (cmd) begin
                m_shift     = {addr, 1'b0};
                m_data_hold = data;
                m_acked     = 1'b0;
                m_in_data   = 1'b0;
                m_bit_cnt   = 4'd0;
                enter_step(S_START, 1'b0, 1'b1);
            end
        end else if (m_wait > 16'd1) begin
            m_wait = m_wait - 16'd1;
        end else begin
            done = (m_step == S_STOP_SDA_REL);
            case (m_step)
                S_START: begin
                    m_bit_cnt = 4'd0;
                    enter_step(S_BIT_SCL_LOW, 1'b1, ~m_shift[7]);
                end
                S_BIT_SCL_LOW: begin
                    enter_step(S_BIT_SCL_HIGH, 1'b0, m_sda_low);
                end
                S_BIT_SCL_HIGH: begin
                    m_bit_cnt = m_bit_cnt + 4'd1;
                    m_shift   = m_shift << 1;
                    if (m_bit_cnt < 4'd8) begin
                        enter_step(S_BIT_SCL_LOW, 1'b1, ~m_shift[7]);
                    end else begin
                        enter_step(S_ACK_SCL_LOW, 1'b1, 1'b0);
                    end
                end
                S_ACK_SCL_LOW: begin
                    enter_step(S_ACK_SCL_HIGH, 1'b0, 1'b0);
                end
                S_ACK_SCL_HIGH: begin
                    // Only an acknowledged address leads on to the data byte.
                    if (!m_in_data && !sda) begin
                        m_acked   = 1'b1;
                        m_in_data = 1'b1;
                        m_shift   = m_data_hold;
                        m_bit_cnt = 4'd0;
                        enter_step(S_BIT_SCL_LOW, 1'b1, ~m_shift[7]);
                    end else begin
                        enter_step(S_STOP_SCL_LOW, 1'b1, 1'b1);
                    end
                end
                S_STOP_SCL_LOW: begin
                    enter_step(S_STOP_SCL_REL, 1'b0, 1'b1);
                end
                S_STOP_SCL_REL: begin
                    enter_step(S_STOP_SDA_REL, 1'b0, 1'b0);
                end
                default: begin
                    m_step    = S_IDLE;
                    m_scl_low = 1'b0;
                    m_sda_low = 1'b0;
                    m_wait    = 16'd0;
                    m_in_data = 1'b0;
                end
            endcase
        end
        r.scl_drive_low = m_scl_low;
        r.sda_drive_low = m_sda_low;
        r.busy_res      = (m_step != S_IDLE);
        r.done_res      = done;
        r.addr_acked    = m_acked;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result stalls follow segments of random length, each with its own pattern.
    initial begin : result_stall
        int seg;
        int mode;
        bus_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 40);
            repeat (seg) begin
                @(negedge i_clk);
                case (mode)
                    0: bus_ch.ready <= 1'b1;
                    1: bus_ch.ready <= 1'($urandom_range(0, 1));
                    2: bus_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: bus_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        i2cmbw_pkg::t_result got;
        i2cmbw_pkg::t_result want;
        if (i_rst_n) begin
            if (bus_ch.valid && bus_ch.ready) begin
                got.scl_drive_low = bus_ch.scl_drive_low;
                got.sda_drive_low = bus_ch.sda_drive_low;
                got.busy_res      = bus_ch.busy_res;
                got.done_res      = bus_ch.done_res;
                got.addr_acked    = bus_ch.addr_acked;
                if (expected_bus.size() == 0) begin
                    report_mismatch("result transaction with no expectation waiting");
                end else begin
                    want = expected_bus.pop_front();
                    if (got.scl_drive_low !== want.scl_drive_low)
                        report_mismatch($sformatf("scl_drive_low got %b expected %b",
                                                  got.scl_drive_low, want.scl_drive_low));
                    if (got.sda_drive_low !== want.sda_drive_low)
                        report_mismatch($sformatf("sda_drive_low got %b expected %b",
                                                  got.sda_drive_low, want.sda_drive_low));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %b expected %b",
                                                  got.busy_res, want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %b expected %b",
                                                  got.done_res, want.done_res));
                    if (got.addr_acked !== want.addr_acked)
                        report_mismatch($sformatf("addr_acked got %b expected %b",
                                                  got.addr_acked, want.addr_acked));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                m_half = cfg_ch.data;
                cfg_taken++;
            end
            if (tick_ch.valid && tick_ch.ready) begin
                expected_bus.push_back(predict_tick(tick_ch.cmd, tick_ch.dev_addr,
                                                    tick_ch.data_byte, tick_ch.sda_in));
                ticks_taken++;
            end
        end
    end

    // Sends one tick; the sender works in bursts with short gaps in between.
    task automatic send_tick(input bit cmd, input bit [6:0] addr, input bit [7:0] data,
                             input bit sda);
        int seen;
        if (burst_left == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        tick_ch.valid     <= 1'b1;
        tick_ch.cmd       <= cmd;
        tick_ch.dev_addr  <= addr;
        tick_ch.data_byte <= data;
        tick_ch.sda_in    <= sda;
        seen = ticks_taken;
        do @(negedge i_clk); while (ticks_taken == seen);
    endtask

    // Brings the bus back to idle and waits until every result has come back.
    task automatic drain_bus();
        while (m_step != S_IDLE)
            send_tick(1'b0, 7'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        tick_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_bus.size() != 0);
    endtask

    task automatic write_half_period(input bit [15:0] value);
        int seen;
        drain_bus();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        seen = cfg_taken;
        do @(negedge i_clk); while (cfg_taken == seen);
        cfg_ch.valid <= 1'b0;
    endtask

    // One complete write transaction; the target answers each acknowledge as asked.
    task automatic run_transaction(input bit [6:0] addr, input bit [7:0] data,
                                   input bit ack_addr, input bit ack_data,
                                   input bit poke_busy);
        bit sda;
        while (m_step != S_IDLE)
            send_tick(1'b0, 7'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        send_tick(1'b1, addr, data, 1'($urandom_range(0, 1)));
        while (m_step != S_IDLE) begin
            if (m_step == S_ACK_SCL_HIGH)
                sda = m_in_data ? !ack_data : !ack_addr;
            else
                sda = 1'($urandom_range(0, 1));
            send_tick(poke_busy && ($urandom_range(0, 3) == 0), 7'($urandom), 8'($urandom),
                      sda);
        end
    endtask

    // Runs at the step length that reset leaves behind.
    task automatic test_reset_timing();
        run_transaction(7'h7F, 8'hFF, 1'b0, 1'b1, 1'b0);
    endtask

    // The acknowledge flag must clear when the next request is taken.
    task automatic test_address_nack();
        write_half_period(16'd1);
        run_transaction(7'h2A, 8'h55, 1'b1, 1'b1, 1'b0);
        run_transaction(7'h55, 8'hAA, 1'b0, 1'b1, 1'b0);
        run_transaction(7'h01, 8'h80, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_request_while_busy();
        write_half_period(16'd1);
        run_transaction(7'h3C, 8'h96, 1'b1, 1'b1, 1'b1);
        run_transaction(7'h43, 8'h69, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_zero_step();
        write_half_period(16'd0);
        run_transaction(7'h6B, 8'h0F, 1'b1, 1'b1, 1'b0);
        run_transaction(7'h14, 8'hF0, 1'b0, 1'b0, 1'b0);
        write_half_period(16'd1);
        run_transaction(7'h7E, 8'h01, 1'b1, 1'b0, 1'b0);
    endtask

    // The largest step lengths are only held while idle, since a transaction at
    // such a length would take far too long.
    task automatic test_wide_step();
        write_half_period(16'hFFFF);
        repeat (10) send_tick(1'b0, 7'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        write_half_period(16'hAAAA);
        repeat (5) send_tick(1'b0, 7'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        write_half_period(16'h5555);
        repeat (5) send_tick(1'b0, 7'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic();
        bit [15:0] steps[4];
        bit        cmd;
        bit        sda;
        steps = '{16'd1, 16'd0, 16'd2, 16'd1};
        foreach (steps[i]) begin
            write_half_period(steps[i]);
            repeat (12) begin
                if (m_step == S_IDLE)
                    cmd = 1'($urandom_range(0, 1));
                else
                    cmd = ($urandom_range(0, 7) == 0);
                if (m_step == S_ACK_SCL_HIGH)
                    sda = ($urandom_range(0, 3) == 0);
                else
                    sda = 1'($urandom_range(0, 1));
                send_tick(cmd, 7'($urandom), 8'($urandom), sda);
            end
        end
    endtask

    initial begin
        m_step      = S_IDLE;
        m_bit_cnt   = 4'd0;
        m_shift     = 8'd0;
        m_data_hold = 8'd0;
        m_wait      = 16'd0;
        m_half      = i2cmbw_pkg::HALF_PERIOD_RESET;
        m_acked     = 1'b0;
        m_in_data   = 1'b0;
        m_scl_low   = 1'b0;
        m_sda_low   = 1'b0;
        mismatches  = 0;
        ticks_taken = 0;
        cfg_taken   = 0;
        burst_left  = 0;

        tick_ch.valid     = 1'b0;
        tick_ch.cmd       = 1'b0;
        tick_ch.dev_addr  = 7'd0;
        tick_ch.data_byte = 8'd0;
        tick_ch.sda_in    = 1'b1;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timing();
        test_address_nack();
        test_request_while_busy();
        test_zero_step();
        test_wide_step();
        test_random_traffic();

        drain_bus();
        repeat (20) @(negedge i_clk);
        if (expected_bus.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_bus.size()));
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
